// File: src/sira_pkg.sv
// Shared types, constants and helper functions for the signed integer to ASCII converter.
// Used by the serial divider, the digit stack and the top level. No dependencies.
package sira_pkg;

	// ASCII codes used in the output text.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOWA  = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// Radix bounds and field widths.
	localparam int RADIX_BITS = 5;
	localparam int DIGIT_BITS = 4;
	localparam int CHAR_BITS  = 8;
	localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} sira_state_t;

	// Status returned by the serial divider at the end of one division.
	typedef struct packed {
		logic                  done;
		logic [DIGIT_BITS-1:0] rem;
	} sira_div_stat_t;

	// Force a radix code into the supported range of 2 to 16.
	function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
		logic [RADIX_BITS-1:0] res;
		begin
			if (r < RADIX_MIN) begin
				res = RADIX_MIN;
			end else if (r > RADIX_MAX) begin
				res = RADIX_MAX;
			end else begin
				res = r;
			end
			return res;
		end
	endfunction

	// Map a digit value to its lower-case ASCII character.
	function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
		logic [CHAR_BITS-1:0] res;
		begin
			if (d < 4'd10) begin
				res = CH_ZERO + {4'd0, d};
			end else begin
				res = CH_LOWA + {4'd0, d} - 8'd10;
			end
			return res;
		end
	endfunction

endpackage

// File: src/sira_div.sv
// Serial divider: divides an unsigned value by a radix of 2..16, two quotient bits per cycle.
// Depends on sira_pkg for the status struct and field widths.
module sira_div import sira_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [RADIX_BITS-1:0] radix,
	output logic [VALUE_BITS-1:0] quotient,
	output sira_div_stat_t        stat
);

	// The dividend is padded to an even width so that two bits retire per cycle.
	localparam int DIV_BITS = VALUE_BITS + (VALUE_BITS % 2);
	localparam int STEPS    = DIV_BITS / 2;
	localparam int CNT_W    = $clog2(STEPS + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIV_BITS-1:0]   sh_q;
	logic [DIGIT_BITS-1:0] rem_q;
	logic [RADIX_BITS-1:0] radix_q;

	logic [RADIX_BITS-1:0] t1, t2, d1, d2;
	logic                  qb1, qb0;
	logic [DIGIT_BITS-1:0] r1, r2;

	// Two restoring steps: remainder stays below the radix, so four bits hold it.
	always_comb begin
		t1  = {rem_q, sh_q[DIV_BITS-1]};
		qb1 = (t1 >= radix_q);
		d1  = t1 - radix_q;
		r1  = qb1 ? d1[DIGIT_BITS-1:0] : t1[DIGIT_BITS-1:0];
		t2  = {r1, sh_q[DIV_BITS-2]};
		qb0 = (t2 >= radix_q);
		d2  = t2 - radix_q;
		r2  = qb0 ? d2[DIGIT_BITS-1:0] : t2[DIGIT_BITS-1:0];
	end

	// Control of the iteration count and the completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend bits shift out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q    <= DIV_BITS'(dividend);
			rem_q   <= '0;
			radix_q <= radix;
		end else if (busy_q) begin
			sh_q  <= {sh_q[DIV_BITS-3:0], qb1, qb0};
			rem_q <= r2;
		end
	end

	assign quotient  = sh_q[VALUE_BITS-1:0];
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

// File: src/sira_stack.sv
// Digit stack: holds the digits of one number, least significant first, for reversal.
// Depends on sira_pkg for the digit width.
module sira_stack import sira_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DIGIT_BITS-1:0]    wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DIGIT_BITS-1:0]    rd_data
);

	logic [DIGIT_BITS-1:0] mem_q [DEPTH];
	logic [DIGIT_BITS-1:0] rd_data_q;

	// One write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// One registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/signed_int_to_ascii_radix_top.sv
// Signed integer to ASCII text in radix 2..16, one character per output transfer, MSB first.
// Each digit costs one serial division of the remaining quotient by the radix.
// One number is converted at a time; the next is accepted while the last character still waits.
// arst_n clears sequencer, digit count, divider control, output valid; data registers do not reset.
// Depends on sira_pkg, sira_div and sira_stack.
module signed_int_to_ascii_radix_top import sira_pkg::*; #(
	parameter int VALUE_BITS = 32,
	localparam int IN_W = ((VALUE_BITS + RADIX_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,  // value [VALUE_BITS-1:0], radix [VALUE_BITS+4:VALUE_BITS]
	// Output stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [CHAR_BITS-1:0] m_tdata,  // character [7:0]
	output logic                 m_tlast
);

	localparam int AW = $clog2(VALUE_BITS);
	localparam int CW = $clog2(VALUE_BITS + 1);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	sira_state_t state_q, state_d;

	logic [CW-1:0]         cnt_q;
	logic [RADIX_BITS-1:0] radix_q;
	logic                  neg_q;
	logic                  m_tvalid_q;
	logic [CHAR_BITS-1:0]  char_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] in_value, in_mag;
	logic                  in_neg;
	logic [RADIX_BITS-1:0] in_radix;
	logic                  in_take;
	logic                  out_free;

	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [RADIX_BITS-1:0] div_radix;
	logic [VALUE_BITS-1:0] div_quot;
	sira_div_stat_t        div_stat;

	logic                  wr_en, rd_en;
	logic [CW-1:0]         rd_idx;
	logic [DIGIT_BITS-1:0] rd_digit;

	logic                  out_load;
	logic [CHAR_BITS-1:0]  out_char;
	logic                  out_last;
	logic                  cnt_inc, cnt_dec;

	// Input fields, sign and magnitude as an unsigned number.
	assign in_value = s_tdata[VALUE_BITS-1:0];
	assign in_neg   = in_value[VALUE_BITS-1];
	assign in_mag   = in_neg ? (~in_value + 1'b1) : in_value;
	assign in_radix = clamp_radix(s_tdata[VALUE_BITS+RADIX_BITS-1:VALUE_BITS]);
	assign in_take  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_idx   = cnt_q - 1'b1;

	sira_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.radix    (div_radix),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	sira_stack #(
		.DEPTH(VALUE_BITS)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (div_stat.rem),
		.rd_en   (rd_en),
		.rd_addr (rd_idx[AW-1:0]),
		.rd_data (rd_digit)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control: divide to a zero quotient, emit '-' if negative, then pop the digits.
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = div_quot;
		div_radix    = radix_q;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		out_load     = 1'b0;
		out_char     = digit_char(rd_digit);
		out_last     = 1'b0;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				div_dividend = in_mag;
				div_radix    = in_radix;
				if (s_tvalid) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					wr_en   = 1'b1;
					cnt_inc = 1'b1;
					if (div_quot == '0) begin
						state_d = ST_SIGN;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			ST_SIGN: begin
				if (!neg_q) begin
					state_d = ST_READ;
				end else if (out_free) begin
					out_load = 1'b1;
					out_char = CH_MINUS;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = (cnt_q == CNT_ONE);
					cnt_dec  = 1'b1;
					state_d  = (cnt_q == CNT_ONE) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Digit count: rises while dividing, falls while emitting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_take) begin
			cnt_q <= '0;
		end else if (cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cnt_dec) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Item attributes kept for the whole conversion.
	always_ff @(posedge clk) begin
		if (in_take) begin
			radix_q <= in_radix;
			neg_q   <= in_neg;
		end
	end

	// Output register: a character waits here until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for signed_int_to_ascii_radix_top: integers go in, ASCII characters are checked.
// It predicts the text of each number itself and compares every character and last flag.
// Depends on sira_pkg and the RTL of the converter only.
module tb_top;
	import sira_pkg::*;

	localparam int VALUE_BITS  = 32;
	localparam int IN_W        = ((VALUE_BITS + RADIX_BITS + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_NUMS = 108;
	localparam int SETTLE      = 100;

	// One character of the expected text.
	typedef struct packed {
		logic [CHAR_BITS-1:0] ch;
		logic                 last;
	} ascii_char_t;

	// Predicts the text of each accepted number and checks the characters that come out.
	class text_scoreboard;
		ascii_char_t text_q[$];
		int          mismatches;

		function new();
			mismatches = 0;
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		// Work out the characters that one accepted number must produce.
		function void note_number(logic [VALUE_BITS-1:0] value, logic [RADIX_BITS-1:0] radix_code);
			logic [VALUE_BITS-1:0] mag;
			int unsigned           base;
			logic [3:0]            digits[$];
			ascii_char_t           c;
			base = (radix_code < 2) ? 2 : ((radix_code > 16) ? 16 : radix_code);
			// The magnitude is unsigned, so the most negative value needs no patch.
			mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
			if (value[VALUE_BITS-1]) begin
				c.ch   = CH_MINUS;
				c.last = 1'b0;
				text_q.push_back(c);
			end
			do begin
				digits.push_front(4'(mag % base));
				mag = mag / base;
			end while (mag != 0);
			foreach (digits[i]) begin
				c.ch   = (digits[i] < 4'd10) ? CH_ZERO + {4'd0, digits[i]}
					: CH_LOWA + {4'd0, digits[i]} - 8'd10;
				c.last = (i == digits.size() - 1);
				text_q.push_back(c);
			end
		endfunction

		// Compare one output transfer with the oldest expected character.
		task check_char(logic [CHAR_BITS-1:0] ch, logic last);
			ascii_char_t want;
			if (text_q.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h last=%0b", ch, last));
			end else begin
				want = text_q.pop_front();
				if (ch !== want.ch) begin
					report_mismatch($sformatf("character 0x%02h, expected 0x%02h", ch, want.ch));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("last %0b, expected %0b (character 0x%02h)",
						last, want.last, want.ch));
				end
			end
		endtask

		function int pending();
			return text_q.size();
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata;
	logic            m_tvalid;
	logic            m_tready;
	logic [7:0]      m_tdata;
	logic            m_tlast;

	text_scoreboard sb;
	bit             calm;
	int             cycles;

	signed_int_to_ascii_radix_top #(.VALUE_BITS(VALUE_BITS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap(int pct);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r >= pct) begin
			return 0;
		end
		if (r < pct * 4 / 5) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Present one number at a falling edge and hold it until the transfer.
	task automatic send_number(logic [VALUE_BITS-1:0] value, logic [RADIX_BITS-1:0] radix_code);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - VALUE_BITS - RADIX_BITS){1'b0}}, radix_code, value};
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.note_number(value, radix_code);
		@(negedge clk);
	endtask

	task automatic sender_idle(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Hold off new input until every expected character has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
	endtask

	// Random number: full-range, small, or near the extremes.
	function automatic logic [VALUE_BITS-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return $urandom;
		end else if (r < 8) begin
			return $urandom_range(0, 1) ? $urandom_range(0, 300) : -$urandom_range(1, 300);
		end
		return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 20)
			: 32'h8000_0000 + $urandom_range(0, 20);
	endfunction

	// Radix code: usually in range, sometimes any 5-bit code to exercise clamping.
	function automatic logic [RADIX_BITS-1:0] pick_radix();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(2, 16);
		end
		return $urandom_range(0, 31);
	endfunction

	// Output side: random back-pressure, checked at every rising edge.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				sb.check_char(m_tdata, m_tlast);
			end
			@(negedge clk);
			if (stall_left == 0) begin
				stall_left = pick_gap(20);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("signed_int_to_ascii_radix_top verification failed");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		logic [VALUE_BITS-1:0] dir_val[$];
		logic [RADIX_BITS-1:0] dir_rad[$];
		sb       = new();
		calm     = 1'b1;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero, extremes, clamped radix codes and every hex letter.
		dir_val = '{32'd0, 32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'hffff_ffff, 32'h7edc_ba98, 32'h8543_2110, 32'd123456789,
			-32'sd987654321, 32'd35, 32'd9, 32'd10, 32'd15, 32'd255};
		dir_rad = '{5'd10, 5'd2, 5'd16, 5'd10, 5'd2, 5'd16, 5'd2, 5'd10, 5'd16, 5'd3,
			5'd7, 5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd9, 5'd4, 5'd10, 5'd11,
			5'd16, 5'd13};
		foreach (dir_val[i]) begin
			send_number(dir_val[i], dir_rad[i]);
		end
		wait_drained();

		// Random part, with a stretch of no idling and one full drain along the way.
		calm = 1'b0;
		for (int n = 0; n < RANDOM_NUMS; n++) begin
			calm = (n >= 50 && n < 70);
			if (n == 100) begin
				wait_drained();
			end
			send_number(pick_value(), pick_radix());
			sender_idle(pick_gap(45));
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("signed_int_to_ascii_radix_top verification clean");
		end else begin
			$display("signed_int_to_ascii_radix_top verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
src/sira_pkg.sv
src/sira_div.sv
src/sira_stack.sv
src/signed_int_to_ascii_radix_top.sv
dv/tb_top.sv
